### rtl/mtep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants of the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned VLQ_MAX_BYTES = 4;
  localparam int unsigned VCNT_W        = 3;

  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_PRESSURE   = 4'hD;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;

  localparam logic EVT_CHANNEL = 1'b0;
  localparam logic EVT_TEMPO   = 1'b1;

  localparam int unsigned TDATA_W = 112;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_last;
    logic       track_first;
  } mtep_byte_t;

  typedef struct packed {
    logic [27:0] delta_ticks;
    logic [31:0] event_tick;
    logic        event_type;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_value;
  } mtep_result_t;

endpackage
`default_nettype wire

### rtl/midi_track_event_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit
// Standard MIDI file track parser: bytes in, channel and tempo events out.
// ----------------------------------------------------------------------------
// Slave side takes one track byte per beat: s_tdata is the byte, s_tlast
// marks the last byte of the track, s_tuser[0] marks the first byte (clears
// running status, tick and parser state before the byte is parsed).
// Master side gives one beat per complete channel message or tempo change.
// Bytes go through an input register, the parser update, and a result
// register; the result of a completing byte is registered in the result
// register when the parser advances on it. Throughput is one byte per cycle
// unless a held result stalls it; bytes that complete no event give no beat.
// When m_tready is low the result holds; the input register still takes
// bytes that give no result, and s_tready drops once a byte with a result
// would overwrite the held beat.
// Reset (rst, synchronous) empties both registers and puts the parser in
// the delta-time state with running status and tick zero. No clearing pass.
// Bytes after track end are ignored until a byte marked first.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit import mtep_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,   // data_byte
  input  wire logic               s_tlast,   // track_last
  input  wire logic [0:0]         s_tuser,   // track_first
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // delta_ticks, event_tick, status_byte, first_data, second_data,
  // tempo_value, zero pad
  output logic [TDATA_W-1:0]      m_tdata,
  output logic [0:0]              m_tuser    // event_type
);

  mtep_byte_t   in_reg;
  logic         in_valid;
  logic         advance;
  logic         emit;
  logic         out_free;
  mtep_result_t result;

  assign advance  = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg <= '{data_byte: s_tdata, track_last: s_tlast, track_first: s_tuser[0]};
    end
  end

  mtep_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (in_reg),
    .emit    (emit),
    .result  (result)
  );

  mtep_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .result   (result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // a held byte is never lost or altered while it waits
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_reg))
    else $error("input register lost a waiting byte");

  // tempo beats carry status 0xFF and no data bytes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[67:60] == STATUS_META && m_tdata[81:68] == '0)
    else $error("malformed tempo result");

  // channel beats carry no tempo
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[105:82] == '0)
    else $error("channel result with tempo value");

  // a result is never overwritten before it is taken
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

### rtl/mtep_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_parser
// Parser state and its one-byte update; flags a complete event.
// ----------------------------------------------------------------------------
module mtep_parser import mtep_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         advance,
  input  wire mtep_byte_t   in_byte,
  output logic              emit,
  output mtep_result_t      result
);

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_LEN, PH_TEMPO, PH_SKIP
  } phase_t;

  phase_t             phase, phase_next;
  logic [27:0]        delta_accum, delta_accum_next;
  logic [VCNT_W-1:0]  vcnt, vcnt_next;
  logic [7:0]         running_status, running_status_next;
  logic [7:0]         current_status, current_status_next;
  logic [6:0]         data_hold, data_hold_next;
  logic [23:0]        tempo_accum, tempo_accum_next;
  logic [7:0]         meta_type, meta_type_next;
  logic [27:0]        skip_remaining, skip_remaining_next;
  logic [31:0]        tick_total, tick_total_next;
  logic               track_done, track_done_next;

  logic [7:0]         b;
  logic [VCNT_W-1:0]  vcnt_inc;

  assign b = in_byte.data_byte;

  function automatic logic one_data(input logic [7:0] st);
    return (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE);
  endfunction

  always_comb begin
    phase_next          = phase;
    delta_accum_next    = delta_accum;
    vcnt_next           = vcnt;
    running_status_next = running_status;
    current_status_next = current_status;
    data_hold_next      = data_hold;
    tempo_accum_next    = tempo_accum;
    meta_type_next      = meta_type;
    skip_remaining_next = skip_remaining;
    tick_total_next     = tick_total;
    track_done_next     = track_done;
    emit                = 1'b0;
    result              = '0;

    if (in_byte.track_first) begin
      phase_next          = PH_DELTA;
      delta_accum_next    = '0;
      vcnt_next           = '0;
      running_status_next = '0;
      current_status_next = '0;
      data_hold_next      = '0;
      tempo_accum_next    = '0;
      meta_type_next      = '0;
      skip_remaining_next = '0;
      tick_total_next     = '0;
      track_done_next     = 1'b0;
    end

    vcnt_inc = vcnt_next + VCNT_W'(1);

    if (!track_done_next) begin
      case (phase_next)
        PH_DELTA: begin
          if (vcnt_next == '0) begin
            delta_accum_next = {21'd0, b[6:0]};
          end else begin
            delta_accum_next = {delta_accum_next[20:0], b[6:0]};
          end
          vcnt_next = vcnt_inc;
          if (!b[7] || vcnt_inc >= VCNT_W'(VLQ_MAX_BYTES)) begin
            tick_total_next = tick_total_next + {4'd0, delta_accum_next};
            vcnt_next       = '0;
            phase_next      = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (!b[7]) begin
            current_status_next = running_status_next;
            data_hold_next      = b[6:0];
            if (one_data(running_status_next)) begin
              emit = 1'b1;
            end else begin
              phase_next = PH_DATA2;
            end
          end else if (b == STATUS_META) begin
            phase_next = PH_MTYPE;
          end else if (b inside {STATUS_SYSEX, STATUS_ESCAPE}) begin
            meta_type_next      = b;
            skip_remaining_next = '0;
            vcnt_next           = '0;
            phase_next          = PH_LEN;
          end else if (b[7:4] != HI_SYSTEM) begin
            running_status_next = b;
            current_status_next = b;
            phase_next          = PH_DATA1;
          end else begin
            // system common / realtime byte: ignored
            phase_next = PH_DELTA;
            vcnt_next  = '0;
          end
        end
        PH_DATA1: begin
          data_hold_next = b[6:0];
          if (one_data(current_status_next)) begin
            emit = 1'b1;
          end else begin
            phase_next = PH_DATA2;
          end
        end
        PH_DATA2: begin
          emit = 1'b1;
        end
        PH_MTYPE: begin
          meta_type_next      = b;
          skip_remaining_next = '0;
          vcnt_next           = '0;
          phase_next          = PH_LEN;
        end
        PH_LEN: begin
          skip_remaining_next = {skip_remaining_next[20:0], b[6:0]};
          vcnt_next           = vcnt_inc;
          if (!b[7] || vcnt_inc >= VCNT_W'(VLQ_MAX_BYTES)) begin
            vcnt_next = '0;
            if (meta_type_next == META_TEMPO && skip_remaining_next == 28'd3) begin
              tempo_accum_next = '0;
              phase_next       = PH_TEMPO;
            end else if (skip_remaining_next == '0) begin
              phase_next = PH_DELTA;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_TEMPO: begin
          tempo_accum_next = {tempo_accum_next[15:0], b};
          vcnt_next        = vcnt_inc;
          if (vcnt_inc >= VCNT_W'(3)) begin
            emit = 1'b1;
          end
        end
        PH_SKIP: begin
          if (skip_remaining_next != '0) begin
            skip_remaining_next = skip_remaining_next - 28'd1;
          end
          if (skip_remaining_next == '0) begin
            phase_next = PH_DELTA;
            vcnt_next  = '0;
          end
        end
        default: begin
          phase_next = PH_DELTA;
          vcnt_next  = '0;
        end
      endcase

      if (emit) begin
        result.delta_ticks = delta_accum_next;
        result.event_tick  = tick_total_next;
        if (phase_next == PH_TEMPO) begin
          result.event_type  = EVT_TEMPO;
          result.status_byte = STATUS_META;
          result.tempo_value = tempo_accum_next;
        end else begin
          result.event_type  = EVT_CHANNEL;
          result.status_byte = current_status_next;
          result.first_data  = data_hold_next;
          if (phase_next == PH_DATA2) begin
            result.second_data = b[6:0];
          end
        end
        phase_next = PH_DELTA;
        vcnt_next  = '0;
      end

      if (in_byte.track_last) begin
        // cut-off event is dropped; keep running status and tick
        track_done_next     = 1'b1;
        phase_next          = PH_DELTA;
        delta_accum_next    = '0;
        vcnt_next           = '0;
        current_status_next = '0;
        data_hold_next      = '0;
        tempo_accum_next    = '0;
        meta_type_next      = '0;
        skip_remaining_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      delta_accum    <= '0;
      vcnt           <= '0;
      running_status <= '0;
      current_status <= '0;
      data_hold      <= '0;
      tempo_accum    <= '0;
      meta_type      <= '0;
      skip_remaining <= '0;
      tick_total     <= '0;
      track_done     <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      delta_accum    <= delta_accum_next;
      vcnt           <= vcnt_next;
      running_status <= running_status_next;
      current_status <= current_status_next;
      data_hold      <= data_hold_next;
      tempo_accum    <= tempo_accum_next;
      meta_type      <= meta_type_next;
      skip_remaining <= skip_remaining_next;
      tick_total     <= tick_total_next;
      track_done     <= track_done_next;
    end
  end

endmodule
`default_nettype wire

### rtl/mtep_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_out_reg
// Result register driving the master stream side.
// ----------------------------------------------------------------------------
module mtep_out_reg import mtep_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire mtep_result_t       result,
  output logic                    out_free,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,
  output logic [0:0]              m_tuser
);

  mtep_result_t held;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {6'd0, held.tempo_value, held.second_data, held.first_data,
                    held.status_byte, held.event_tick, held.delta_ticks};
  assign m_tuser = held.event_type;

endmodule
`default_nettype wire

### dv/midi_track_event_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit_tb
// Streams MIDI track bytes into the parser and checks every channel and tempo
// event it reports against an in-bench model of the track parser. A short
// directed track hits the corner cases, then random tracks follow: mostly
// well-formed, some cut short, some pure noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtep_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_BYTES   = 1950;
  localparam int unsigned SETTLE_CYCLES  = 20;

  typedef enum logic [3:0] {
    PS_DELTA, PS_STATUS, PS_DATA1, PS_DATA2, PS_MTYPE, PS_LEN, PS_TEMPO, PS_SKIP
  } parse_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = '0;   // data_byte
  logic               s_tlast  = 1'b0; // track_last
  logic [0:0]         s_tuser  = '0;   // track_first
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // delta_ticks, event_tick, status_byte, first_data, second_data,
  // tempo_value, zero pad
  logic [TDATA_W-1:0] m_tdata;
  logic [0:0]         m_tuser;         // event_type

  always #5 clk = ~clk;

  midi_track_event_parser_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // --------------------------------------------------------------------------
  // Track parser model
  // --------------------------------------------------------------------------
  parse_phase_e ps          = PS_DELTA;
  logic [27:0]  delta_acc   = '0;
  logic [2:0]   vlq_cnt     = '0;
  logic [7:0]   run_st      = '0;
  logic [7:0]   cur_st      = '0;
  logic [7:0]   held_data   = '0;
  logic [23:0]  tempo_acc   = '0;
  logic [7:0]   meta_kind   = '0;
  logic [27:0]  skip_left   = '0;
  logic [31:0]  tick_sum    = '0;
  logic         track_ended = 1'b0;

  mtep_result_t expected_events[$];
  mtep_byte_t   track_beats[$];

  int mismatches = 0;

  function automatic bit one_data_status(logic [7:0] st);
    return st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE;
  endfunction

  task automatic clear_parser();
    ps        = PS_DELTA;
    delta_acc = '0;
    vlq_cnt   = '0;
    cur_st    = '0;
    held_data = '0;
    tempo_acc = '0;
    meta_kind = '0;
    skip_left = '0;
  endtask

  task automatic push_event(logic typ, logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                            logic [23:0] tempo);
    mtep_result_t ev;
    ev.delta_ticks = delta_acc;
    ev.event_tick  = tick_sum;
    ev.event_type  = typ;
    ev.status_byte = st;
    ev.first_data  = d1;
    ev.second_data = d2;
    ev.tempo_value = tempo;
    expected_events.push_back(ev);
    ps      = PS_DELTA;
    vlq_cnt = '0;
  endtask

  task automatic parse_track_byte(logic [7:0] b);
    case (ps)
      PS_DELTA: begin
        if (vlq_cnt == 0) delta_acc = '0;
        delta_acc = {delta_acc[20:0], b[6:0]};
        vlq_cnt++;
        if (!b[7] || vlq_cnt >= VLQ_MAX_BYTES) begin
          tick_sum += {4'd0, delta_acc};
          vlq_cnt = '0;
          ps = PS_STATUS;
        end
      end
      PS_STATUS: begin
        if (!b[7]) begin
          // data byte right after the delta: running status applies
          cur_st    = run_st;
          held_data = {1'b0, b[6:0]};
          if (one_data_status(cur_st)) push_event(EVT_CHANNEL, cur_st, held_data[6:0], '0, '0);
          else ps = PS_DATA2;
        end else if (b == STATUS_META) begin
          ps = PS_MTYPE;
        end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
          meta_kind = b;
          skip_left = '0;
          vlq_cnt   = '0;
          ps        = PS_LEN;
        end else if (b[7:4] != HI_SYSTEM) begin
          run_st = b;
          cur_st = b;
          ps     = PS_DATA1;
        end else begin
          ps      = PS_DELTA;
          vlq_cnt = '0;
        end
      end
      PS_DATA1: begin
        held_data = {1'b0, b[6:0]};
        if (one_data_status(cur_st)) push_event(EVT_CHANNEL, cur_st, held_data[6:0], '0, '0);
        else ps = PS_DATA2;
      end
      PS_DATA2: begin
        push_event(EVT_CHANNEL, cur_st, held_data[6:0], b[6:0], '0);
      end
      PS_MTYPE: begin
        meta_kind = b;
        skip_left = '0;
        vlq_cnt   = '0;
        ps        = PS_LEN;
      end
      PS_LEN: begin
        skip_left = {skip_left[20:0], b[6:0]};
        vlq_cnt++;
        if (!b[7] || vlq_cnt >= VLQ_MAX_BYTES) begin
          vlq_cnt = '0;
          if (meta_kind == META_TEMPO && skip_left == 28'd3) begin
            tempo_acc = '0;
            ps = PS_TEMPO;
          end else if (skip_left == 0) begin
            ps = PS_DELTA;
          end else begin
            ps = PS_SKIP;
          end
        end
      end
      PS_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        vlq_cnt++;
        if (vlq_cnt >= 3) push_event(EVT_TEMPO, STATUS_META, '0, '0, tempo_acc);
      end
      PS_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) begin
          ps      = PS_DELTA;
          vlq_cnt = '0;
        end
      end
      default: begin
        ps      = PS_DELTA;
        vlq_cnt = '0;
      end
    endcase
  endtask

  task automatic predict_beat(mtep_byte_t x);
    if (x.track_first) begin
      clear_parser();
      run_st      = '0;
      tick_sum    = '0;
      track_ended = 1'b0;
    end
    if (!track_ended) begin
      parse_track_byte(x.data_byte);
      // an event still open at the last byte is dropped
      if (x.track_last) begin
        track_ended = 1'b1;
        clear_parser();
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver, receiver ready and monitor
  // --------------------------------------------------------------------------
  int unsigned cycle_cnt    = 0;
  int unsigned stall_cycles = 0;
  logic        s_took       = 1'b0;
  mtep_byte_t  drv_beat;
  wire         calm = cycle_cnt >= 600 && cycle_cnt < 1400;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (track_beats.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
        drv_beat  = track_beats.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= drv_beat.data_byte;
        s_tlast  <= drv_beat.track_last;
        s_tuser  <= drv_beat.track_first;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= calm || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    mtep_result_t ev;
    cycle_cnt <= cycle_cnt + 1;
    s_took    <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_beat('{s_tdata, s_tlast, s_tuser[0]});
      if (m_tvalid && m_tready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event beat: tdata 0x%0h tuser %0b", m_tdata, m_tuser);
          mismatches++;
        end else begin
          ev = expected_events.pop_front();
          check_field("delta_ticks", ev.delta_ticks, m_tdata[27:0]);
          check_field("event_tick",  ev.event_tick,  m_tdata[59:28]);
          check_field("event_type",  ev.event_type,  m_tuser[0]);
          check_field("status_byte", ev.status_byte, m_tdata[67:60]);
          check_field("first_data",  ev.first_data,  m_tdata[74:68]);
          check_field("second_data", ev.second_data, m_tdata[81:75]);
          check_field("tempo_value", ev.tempo_value, m_tdata[105:82]);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Track generation
  // --------------------------------------------------------------------------
  logic [7:0] track_q[$];
  logic [7:0] gen_run_st;
  bit         gen_big_deltas;
  int         n_items = 0;

  task automatic add_beat(logic [7:0] b, logic last, logic first);
    track_beats.push_back('{b, last, first});
  endtask

  task automatic put_delta();
    int n;
    int r;
    r = $urandom_range(99);
    if (gen_big_deltas) begin
      track_q.push_back(8'hFF); track_q.push_back(8'hFF);
      track_q.push_back(8'hFF); track_q.push_back(8'h7F);
    end else begin
      n = (r < 60) ? 1 : (r < 80) ? 2 : (r < 90) ? 3 : 4;
      for (int i = 0; i < n - 1; i++) track_q.push_back(8'h80 | 8'($urandom_range(127)));
      // a 4-byte quantity may end with its continuation bit still set
      if (n == 4 && $urandom_range(3) == 0) track_q.push_back(8'h80 | 8'($urandom_range(127)));
      else if (r < 10) track_q.push_back(8'h00);
      else track_q.push_back(8'($urandom_range(127)));
    end
  endtask

  task automatic put_length(int len);
    int pad;
    pad = ($urandom_range(99) < 30) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < pad; i++) track_q.push_back(8'h80);
    if (pad == 3 && $urandom_range(1) == 1) track_q.push_back(8'h80 | 8'(len));
    else track_q.push_back(8'(len));
  endtask

  task automatic put_channel();
    logic [7:0] st;
    bit         running;
    int         nd;
    running = ($urandom_range(99) < 20);
    if (running) begin
      st = gen_run_st;
    end else begin
      st = 8'($urandom_range(8'h80, 8'hEF));
      gen_run_st = st;
      track_q.push_back(st);
    end
    nd = one_data_status(st) ? 1 : 2;
    for (int i = 0; i < nd; i++) begin
      if ((i == 0 && running) || $urandom_range(99) >= 10)
        track_q.push_back(8'($urandom_range(127)));
      else
        track_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic put_meta(logic [7:0] kind, int len);
    track_q.push_back(STATUS_META);
    track_q.push_back(kind);
    put_length(len);
    for (int i = 0; i < len; i++) track_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_sysex();
    int len;
    len = $urandom_range(5);
    track_q.push_back($urandom_range(1) ? STATUS_SYSEX : STATUS_ESCAPE);
    put_length(len);
    for (int i = 0; i < len; i++) track_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_system();
    logic [7:0] st;
    do st = 8'($urandom_range(8'hF1, 8'hFE));
    while (st == STATUS_ESCAPE);
    track_q.push_back(st);
  endtask

  task automatic build_track(int n_events);
    int r;
    track_q.delete();
    gen_run_st     = '0;
    gen_big_deltas = ($urandom_range(99) < 5);
    for (int e = 0; e < n_events; e++) begin
      put_delta();
      r = $urandom_range(99);
      if (r < 65) put_channel();
      else if (r < 77) put_meta(META_TEMPO, 3);
      else if (r < 81) put_meta(META_TEMPO, $urandom_range(5));
      else if (r < 88) put_meta(8'($urandom_range(255)), $urandom_range(5));
      else if (r < 95) put_sysex();
      else put_system();
    end
  endtask

  task automatic queue_track(int cut);
    for (int i = 0; i < cut; i++) add_beat(track_q[i], i == cut - 1, i == 0);
    n_items += cut;
    // a few stray bytes after the end: ignored until the next first byte
    if ($urandom_range(99) < 20)
      repeat ($urandom_range(1, 3)) add_beat(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  task automatic queue_noise(int n);
    for (int i = 0; i < n; i++)
      add_beat(8'($urandom_range(255)), $urandom_range(99) < 10, $urandom_range(99) < 10);
    n_items += n;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (track_beats.size() != 0 || s_tvalid || expected_events.size() != 0);
  endtask

  initial begin
    int  r;
    bit  paused;
    paused = 1'b0;

    // running status zero at track start, data high bit dropped
    add_beat(8'h00, 1'b0, 1'b1); add_beat(8'h40, 1'b0, 1'b0); add_beat(8'h92, 1'b0, 1'b0);
    // 4-byte delta ending with continuation bit set, channel pressure
    add_beat(8'hFF, 1'b0, 1'b0); add_beat(8'hFF, 1'b0, 1'b0); add_beat(8'hFF, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b0); add_beat(8'hD5, 1'b0, 1'b0); add_beat(8'hFF, 1'b0, 1'b0);
    // tempo, largest value
    add_beat(8'h00, 1'b0, 1'b0); add_beat(STATUS_META, 1'b0, 1'b0);
    add_beat(META_TEMPO, 1'b0, 1'b0); add_beat(8'h03, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b0); add_beat(8'hFF, 1'b0, 1'b0); add_beat(8'hFF, 1'b0, 1'b0);
    // system common byte is the whole event
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'hF3, 1'b0, 1'b0);
    // tempo meta of zero length
    add_beat(8'h00, 1'b0, 1'b0); add_beat(STATUS_META, 1'b0, 1'b0);
    add_beat(META_TEMPO, 1'b0, 1'b0); add_beat(8'h00, 1'b0, 1'b0);
    // escape sysex skipped by length
    add_beat(8'h00, 1'b0, 1'b0); add_beat(STATUS_ESCAPE, 1'b0, 1'b0);
    add_beat(8'h01, 1'b0, 1'b0); add_beat(8'h99, 1'b0, 1'b0);
    // note on cut off by the track end, then a byte after the end
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'h90, 1'b1, 1'b0); add_beat(8'h40, 1'b0, 1'b0);
    // one-byte track
    add_beat(8'h00, 1'b1, 1'b1);

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait_drained();

    while (n_items < RANDOM_BYTES) begin
      r = $urandom_range(99);
      build_track($urandom_range(3, 20));
      if (r < 80) queue_track(track_q.size());
      else if (r < 90) queue_track($urandom_range(1, track_q.size()));
      else queue_noise($urandom_range(5, 30));
      // hold the sender off once until the pipe is empty
      if (!paused && n_items >= RANDOM_BYTES / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mtep_pkg.sv
rtl/mtep_parser.sv
rtl/mtep_out_reg.sv
rtl/midi_track_event_parser_unit.sv
dv/midi_track_event_parser_unit_tb.sv
